>>> rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 5;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_READ   = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [POS_W-1:0]   position;
        t_word              value;
    } t_in_item;

    typedef struct packed {
        logic               ok;
        t_word              read_value;
        logic [LEN_W-1:0]   length;
    } t_out_item;

    typedef struct packed {
        logic               ins;
        logic               rem;
        logic [POS_W-1:0]   position;
        t_word              value;
    } t_cell_op;

endpackage

>>> rtl/core/ple_stream_if.sv
// ----------------------------------------------------------------------------
// ple_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ple_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: loads the inserted value, takes its left neighbor on an
// insert below it, or its right neighbor on a remove at or below it.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int CAPACITY = 16,
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  ple_pkg::t_cell_op i_op,
    input  ple_pkg::t_word    i_prev,
    input  ple_pkg::t_word    i_next,
    output ple_pkg::t_word    o_data
);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;
    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(CELL_IDX);

    logic [CMP_W-1:0] pos_x;
    ple_pkg::t_word   r_data;
    ple_pkg::t_word   n_data;

    assign pos_x = CMP_W'(i_op.position);

    always_comb begin
        n_data = r_data;
        if (i_op.ins) begin
            if (MY_IDX == pos_x) begin
                n_data = i_op.value;
            end else if (MY_IDX > pos_x) begin
                n_data = i_prev;
            end
        end else if (i_op.rem) begin
            if (MY_IDX >= pos_x) begin
                n_data = i_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
endmodule

>>> rtl/core/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values addressed by position.
// ----------------------------------------------------------------------------
// usage
//   i_in carries one operation per transaction: mode (insert, remove, read,
//   clear), position and value. o_out returns exactly one transaction per
//   operation: ok flag, read value and list length after the operation.
//   entries live in a row of CAPACITY cells; on insert every cell above the
//   position takes its left neighbor, on remove every cell at or above the
//   position takes its right neighbor, all in the same cycle.
//   the result is registered and shows on o_out the cycle after acceptance.
//   throughput: one operation per cycle unless o_out is stalled.
//   a stalled o_out holds its transaction and i_in.ready drops until the
//   result is taken, so at most one result waits at a time.
//   reset empties the list and drops o_out.valid; cell contents are not
//   cleared since only entries below the length are ever read.
//   length is reported modulo 32 when CAPACITY exceeds 31.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ple_stream_if.sink    i_in,
    ple_stream_if.source  o_out
);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int PW      = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;
    localparam int NUM_TAP = (CAPACITY < 32) ? CAPACITY : 32;

    ple_pkg::t_word      cell_data [CAPACITY];
    ple_pkg::t_cell_op   cell_op;

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    ple_pkg::t_out_item  r_out;
    ple_pkg::t_out_item  n_out;

    logic                accept;
    logic                ok;
    logic                full;
    logic [PW-1:0]       pos_x;
    logic [PW-1:0]       cnt_x;
    logic [PW-1:0]       len_x;
    ple_pkg::t_word      tap;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign pos_x = PW'(i_in.data.position);
    assign cnt_x = PW'(r_count);
    assign full  = (r_count == CNT_W'(CAPACITY));

    // read tap over the positions the 5-bit field can reach
    always_comb begin
        tap = '0;
        for (int k = 0; k < NUM_TAP; k++) begin
            if (i_in.data.position == ple_pkg::POS_W'(k)) begin
                tap = cell_data[k];
            end
        end
    end

    always_comb begin
        ok      = 1'b0;
        n_count = r_count;
        n_out.read_value = '0;
        case (i_in.data.mode)
            ple_pkg::MODE_INSERT: begin
                ok = (pos_x <= cnt_x) && !full;
                if (ok) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            ple_pkg::MODE_REMOVE: begin
                ok = (pos_x < cnt_x);
                if (ok) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            ple_pkg::MODE_READ: begin
                ok = (pos_x < cnt_x);
                if (ok) begin
                    n_out.read_value = tap;
                end
            end
            ple_pkg::MODE_CLEAR: begin
                ok      = 1'b1;
                n_count = '0;
            end
            default: begin
                ok      = 1'b1;
                n_count = '0;
            end
        endcase
        len_x        = PW'(n_count);
        n_out.ok     = ok;
        n_out.length = len_x[ple_pkg::LEN_W-1:0];
    end

    assign cell_op.ins      = accept && (i_in.data.mode == ple_pkg::MODE_INSERT) && ok;
    assign cell_op.rem      = accept && (i_in.data.mode == ple_pkg::MODE_REMOVE) && ok;
    assign cell_op.position = i_in.data.position;
    assign cell_op.value    = i_in.data.value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        ple_pkg::t_word prev_data;
        ple_pkg::t_word next_data;

        if (g == 0) begin : g_first
            assign prev_data = i_in.data.value;
        end else begin : g_mid_prev
            assign prev_data = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_data = cell_data[g];
        end else begin : g_mid_next
            assign next_data = cell_data[g+1];
        end

        ple_cell #(
            .CAPACITY (CAPACITY),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_op   (cell_op),
            .i_prev (prev_data),
            .i_next (next_data),
            .o_data (cell_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

>>> rtl/core/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker #(
    parameter int CAPACITY = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input ple_pkg::t_mode               i_in_mode,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_out_ok,
    input ple_pkg::t_word               i_out_read_value,
    input logic [ple_pkg::LEN_W-1:0]    i_out_length
);
    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_length)
        && $stable(i_out_ok) && $stable(i_out_read_value))
        else $error("stalled result changed");

    // every accepted transaction yields a result next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted transaction produced no result");

    // clear always succeeds and empties the list
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_mode == ple_pkg::MODE_CLEAR)
        |=> i_out_ok && (i_out_length == '0) && (i_out_read_value == '0))
        else $error("clear result wrong");

    // length stays within capacity
    a_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_out_length) <= CAPACITY))
        else $error("length above capacity");

    // a non-read operation returns zero data
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_mode != ple_pkg::MODE_READ)
        |=> (i_out_read_value == '0))
        else $error("nonzero data on non-read transaction");
endmodule

bind positional_list_engine ple_checker #(
    .CAPACITY (CAPACITY)
) u_ple_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_mode        (i_in.data.mode),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_ok         (o_out.data.ok),
    .i_out_read_value (o_out.data.read_value),
    .i_out_length     (o_out.data.length)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional list engine. A driver feeds
// insert, remove, read and clear transactions from a queue. A shadow list
// predicts each result, and a monitor compares every returned transaction
// field by field. The stimulus starts with boundary cases, then runs
// grow, shrink and mixed phases so the list fills up and drains out.
// Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIST_CAP    = 16;
    localparam int RANDOM_OPS  = 1900;
    localparam int STALL_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n;
    logic calm;

    ple_stream_if #(.T(ple_pkg::t_in_item))  op_ch ();
    ple_stream_if #(.T(ple_pkg::t_out_item)) res_ch ();

    positional_list_engine #(.CAPACITY(LIST_CAP)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch),
        .o_out   (res_ch)
    );

    ple_pkg::t_in_item  pending_ops[$];
    ple_pkg::t_out_item expected_replies[$];
    ple_pkg::t_word     shadow_entries[LIST_CAP];
    int                 shadow_count;
    int                 gen_len;
    int                 ops_total;
    int                 ops_accepted;
    int                 mismatches;
    int                 cycle_count;
    int                 quiet_cycles;
    int                 op_gap;
    int                 res_stall;

    // no new gaps or stalls start while cycle_count modulo 1024 is 768 or more
    assign calm = (cycle_count % 1024) >= 768;

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic ple_pkg::t_word pick_value();
        case ($urandom_range(0, 11))
            0:       return ple_pkg::t_word'(32'h8000_0000);
            1:       return ple_pkg::t_word'(32'h7fff_ffff);
            2:       return ple_pkg::t_word'(32'h0000_0000);
            3:       return ple_pkg::t_word'(32'hffff_ffff);
            default: return ple_pkg::t_word'($urandom);
        endcase
    endfunction

    // queue one operation and track the expected length for position shaping
    function automatic void queue_op(ple_pkg::t_mode mode, int pos, ple_pkg::t_word val);
        ple_pkg::t_in_item op;
        op.mode     = mode;
        op.position = pos[ple_pkg::POS_W-1:0];
        op.value    = val;
        pending_ops.push_back(op);
        case (mode)
            ple_pkg::MODE_INSERT: if (pos <= gen_len && gen_len < LIST_CAP) gen_len++;
            ple_pkg::MODE_REMOVE: if (pos < gen_len) gen_len--;
            ple_pkg::MODE_CLEAR:  gen_len = 0;
            default:              ;
        endcase
    endfunction

    // apply one operation to the shadow list and return the result it gives
    function automatic ple_pkg::t_out_item list_apply(ple_pkg::t_in_item op);
        ple_pkg::t_out_item res;
        int pos;
        res = '0;
        pos = op.position;
        case (op.mode)
            ple_pkg::MODE_INSERT: begin
                if (pos <= shadow_count && shadow_count < LIST_CAP) begin
                    for (int i = shadow_count; i > pos; i--)
                        shadow_entries[i] = shadow_entries[i-1];
                    shadow_entries[pos] = op.value;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            ple_pkg::MODE_REMOVE: begin
                if (pos < shadow_count) begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i+1];
                    shadow_count--;
                    res.ok = 1'b1;
                end
            end
            ple_pkg::MODE_READ: begin
                if (pos < shadow_count) begin
                    res.read_value = shadow_entries[pos];
                    res.ok = 1'b1;
                end
            end
            default: begin
                shadow_count = 0;
                res.ok = 1'b1;
            end
        endcase
        res.length = shadow_count[ple_pkg::LEN_W-1:0];
        return res;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            op_ch.valid <= 1'b0;
            op_gap = 0;
        end else begin
            if (op_ch.valid && op_ch.ready) begin
                expected_replies.push_back(list_apply(op_ch.data));
                ops_accepted++;
            end
            if (!op_ch.valid || op_ch.ready) begin
                if (op_gap > 0 || pending_ops.size() == 0) begin
                    if (op_gap > 0) op_gap--;
                    op_ch.valid <= 1'b0;
                end else begin
                    op_ch.data  <= pending_ops.pop_front();
                    op_ch.valid <= 1'b1;
                    op_gap = calm ? 0 : pick_gap();
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        ple_pkg::t_out_item want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            res_stall = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: unexpected transaction ok=%0b read_value=%0d length=%0d",
                             $time, res_ch.data.ok, res_ch.data.read_value,
                             res_ch.data.length);
                    mismatches++;
                end else begin
                    want = expected_replies.pop_front();
                    if (res_ch.data.ok !== want.ok) begin
                        $display("%0t: ok expected %0b actual %0b",
                                 $time, want.ok, res_ch.data.ok);
                        mismatches++;
                    end
                    if (res_ch.data.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, res_ch.data.read_value);
                        mismatches++;
                    end
                    if (res_ch.data.length !== want.length) begin
                        $display("%0t: length expected %0d actual %0d",
                                 $time, want.length, res_ch.data.length);
                        mismatches++;
                    end
                end
            end
            if (res_stall > 0) begin
                res_stall--;
                res_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                res_stall = pick_gap();
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (!i_rst_n || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int             phase;
        int             plen;
        int             r;
        int             pos;
        ple_pkg::t_mode mode;

        op_ch.valid  = 1'b0;
        op_ch.data   = '0;
        res_ch.ready = 1'b0;
        i_rst_n      = 1'b0;
        gen_len      = 0;

        // empty list, out of range, extremes, middle and last removal
        queue_op(ple_pkg::MODE_READ,   0,  '0);
        queue_op(ple_pkg::MODE_REMOVE, 0,  '0);
        queue_op(ple_pkg::MODE_INSERT, 1,  ple_pkg::t_word'(32'h1234_5678));
        queue_op(ple_pkg::MODE_CLEAR,  0,  '0);
        queue_op(ple_pkg::MODE_INSERT, 0,  ple_pkg::t_word'(32'h8000_0000));
        queue_op(ple_pkg::MODE_INSERT, 1,  ple_pkg::t_word'(32'h7fff_ffff));
        queue_op(ple_pkg::MODE_INSERT, 0,  ple_pkg::t_word'(32'hffff_ffff));
        queue_op(ple_pkg::MODE_INSERT, 3,  ple_pkg::t_word'(32'h0000_0000));
        queue_op(ple_pkg::MODE_INSERT, 5,  ple_pkg::t_word'(32'h5555_aaaa));
        queue_op(ple_pkg::MODE_READ,   0,  '0);
        queue_op(ple_pkg::MODE_READ,   1,  '0);
        queue_op(ple_pkg::MODE_READ,   2,  '0);
        queue_op(ple_pkg::MODE_READ,   3,  '0);
        queue_op(ple_pkg::MODE_READ,   4,  '0);
        queue_op(ple_pkg::MODE_REMOVE, 1,  '0);
        queue_op(ple_pkg::MODE_READ,   1,  '0);
        queue_op(ple_pkg::MODE_REMOVE, 2,  '0);
        queue_op(ple_pkg::MODE_REMOVE, 31, '0);
        queue_op(ple_pkg::MODE_READ,   31, '0);
        queue_op(ple_pkg::MODE_INSERT, 31, ple_pkg::t_word'(32'haaaa_5555));
        queue_op(ple_pkg::MODE_CLEAR,  0,  ple_pkg::t_word'(32'hffff_ffff));
        queue_op(ple_pkg::MODE_READ,   0,  '0);

        // grow, shrink and mixed phases
        ops_total = pending_ops.size() + RANDOM_OPS;
        while (pending_ops.size() < ops_total) begin
            phase = $urandom_range(0, 2);
            plen  = $urandom_range(10, 60);
            repeat (plen) begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    mode = ple_pkg::MODE_CLEAR;
                else if (r < (phase == 0 ? 67 : phase == 1 ? 17 : 35))
                    mode = ple_pkg::MODE_INSERT;
                else if (r < (phase == 0 ? 77 : phase == 1 ? 72 : 65))
                    mode = ple_pkg::MODE_REMOVE;
                else
                    mode = ple_pkg::MODE_READ;
                if ($urandom_range(0, 19) == 0)
                    pos = $urandom_range(0, 31);
                else if (mode == ple_pkg::MODE_INSERT)
                    pos = $urandom_range(0, gen_len);
                else
                    pos = $urandom_range(0, gen_len > 0 ? gen_len - 1 : 0);
                queue_op(mode, pos, pick_value());
            end
        end
        ops_total = pending_ops.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted < ops_total || expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ple_pkg.sv
rtl/core/ple_stream_if.sv
rtl/core/ple_cell.sv
rtl/core/positional_list_engine.sv
rtl/core/ple_checker.sv
tb/sv/testbench.sv
